@@ rtl/sle_pkg.sv @@
// Shared types, constants and codes for the sorted list engine.
package sle_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMP_W       = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [DATA_W-1:0]  value;
        logic [INDEX_W-1:0]        index;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        status_t                   status;
        logic [COUNT_OUT_W-1:0]    entry_count;
    } rsp_t;

    // Read address relative to the next pointer value
    typedef enum logic [1:0] {
        RD_AT    = 2'd0,
        RD_BELOW = 2'd1,
        RD_ABOVE = 2'd2
    } rd_sel_t;

    typedef enum logic {
        WR_VALUE = 1'b0,
        WR_SHIFT = 1'b1
    } wr_src_t;

    typedef enum logic [2:0] {
        PTR_HOLD  = 3'd0,
        PTR_COUNT = 3'd1,
        PTR_INDEX = 3'd2,
        PTR_DEC   = 3'd3,
        PTR_INC   = 3'd4
    } ptr_op_t;

    typedef enum logic [1:0] {
        FIN_ERROR  = 2'd0,
        FIN_INSERT = 2'd1,
        FIN_REMOVE = 2'd2,
        FIN_READ   = 2'd3
    } fin_t;

    typedef struct packed {
        logic     load;
        logic     wr_en;
        wr_src_t  wr_src;
        ptr_op_t  ptr_op;
        rd_sel_t  rd_sel;
        logic     finish;
        fin_t     fin;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       empty;
        logic       idx_oob;
        logic       idx_last;
        logic       ge;
        logic       ptr_one;
        logic       rem_last;
    } flags_t;

endpackage

@@ rtl/sle_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sle_ctrl.sv @@
// Controller state machine for the sorted list engine.
module sle_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sle_pkg::flags_t flags,
    output sle_pkg::cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DECODE    = 6'b000010,
        S_INS_SHIFT = 6'b000100,
        S_INS_PUT   = 6'b001000,
        S_REM_SHIFT = 6'b010000,
        S_RD_WAIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_src = sle_pkg::WR_VALUE;
        cmd.ptr_op = sle_pkg::PTR_HOLD;
        cmd.rd_sel = sle_pkg::RD_AT;
        cmd.fin    = sle_pkg::FIN_ERROR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (flags.mode)
                    sle_pkg::MODE_INSERT:
                    begin
                        if (flags.full)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // start at the top and walk down
                            cmd.ptr_op = sle_pkg::PTR_COUNT;
                            cmd.rd_sel = sle_pkg::RD_BELOW;
                            state_next = flags.empty ? S_INS_PUT : S_INS_SHIFT;
                        end
                    end
                    sle_pkg::MODE_REMOVE:
                    begin
                        if (flags.empty || flags.idx_oob)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (flags.idx_last)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fin    = sle_pkg::FIN_REMOVE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_op = sle_pkg::PTR_INDEX;
                            cmd.rd_sel = sle_pkg::RD_ABOVE;
                            state_next = S_REM_SHIFT;
                        end
                    end
                    sle_pkg::MODE_READ:
                    begin
                        if (flags.idx_oob)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_op = sle_pkg::PTR_INDEX;
                            cmd.rd_sel = sle_pkg::RD_AT;
                            state_next = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_SHIFT:
            begin
                cmd.wr_en = 1'b1;
                if (!flags.ge)
                begin
                    // slot found: drop the new value here
                    cmd.finish = 1'b1;
                    cmd.fin    = sle_pkg::FIN_INSERT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.wr_src = sle_pkg::WR_SHIFT;
                    cmd.ptr_op = sle_pkg::PTR_DEC;
                    cmd.rd_sel = sle_pkg::RD_BELOW;
                    if (flags.ptr_one)
                    begin
                        state_next = S_INS_PUT;
                    end
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.finish = 1'b1;
                cmd.fin    = sle_pkg::FIN_INSERT;
                state_next = S_IDLE;
            end
            S_REM_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = sle_pkg::WR_SHIFT;
                if (flags.rem_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin    = sle_pkg::FIN_REMOVE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.ptr_op = sle_pkg::PTR_INC;
                    cmd.rd_sel = sle_pkg::RD_ABOVE;
                end
            end
            S_RD_WAIT:
            begin
                cmd.finish = 1'b1;
                cmd.fin    = sle_pkg::FIN_READ;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DECODE))
        else $error("accepted word did not enter decode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_src == sle_pkg::WR_SHIFT) |-> !cmd.load)
        else $error("shift write while loading a new word");

endmodule

@@ rtl/sle_dp.sv @@
// Datapath of the sorted list engine: entry store, pointer, count, result.
module sle_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  sle_pkg::req_t   req,
    input  sle_pkg::cmd_t   cmd,
    output sle_pkg::flags_t flags,
    output logic            done,
    output sle_pkg::rsp_t   rsp
);

    logic [1:0]                         mode_reg;
    logic signed [sle_pkg::DATA_W-1:0]  value_reg;
    logic [sle_pkg::INDEX_W-1:0]        idx_reg;
    logic [sle_pkg::CNT_W-1:0]          count_reg;
    logic [sle_pkg::CNT_W-1:0]          count_next;
    logic [sle_pkg::CNT_W-1:0]          ptr_reg;
    logic [sle_pkg::CNT_W-1:0]          ptr_next;
    logic [sle_pkg::CNT_W-1:0]          rd_ptr;
    logic                               done_reg;
    sle_pkg::rsp_t                      rsp_reg;
    sle_pkg::status_t                   err_status;

    logic [sle_pkg::DATA_W-1:0]         rdata;
    logic [sle_pkg::DATA_W-1:0]         wdata;
    logic [sle_pkg::CMP_W-1:0]          idx_cmp;
    logic [sle_pkg::CMP_W-1:0]          cnt_cmp;
    logic [sle_pkg::CNT_W:0]            ptr_plus2;

    sle_ram #(
        .WIDTH (sle_pkg::DATA_W),
        .DEPTH (sle_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (ptr_reg[sle_pkg::ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (rd_ptr[sle_pkg::ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign wdata = (cmd.wr_src == sle_pkg::WR_SHIFT) ? rdata : value_reg;

    always_comb
    begin
        unique case (cmd.ptr_op)
            sle_pkg::PTR_HOLD:  ptr_next = ptr_reg;
            sle_pkg::PTR_COUNT: ptr_next = count_reg;
            sle_pkg::PTR_INDEX: ptr_next = sle_pkg::CNT_W'(idx_reg);
            sle_pkg::PTR_DEC:   ptr_next = ptr_reg - 1'b1;
            sle_pkg::PTR_INC:   ptr_next = ptr_reg + 1'b1;
            default:            ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            sle_pkg::RD_AT:    rd_ptr = ptr_next;
            sle_pkg::RD_BELOW: rd_ptr = ptr_next - 1'b1;
            sle_pkg::RD_ABOVE: rd_ptr = ptr_next + 1'b1;
            default:           rd_ptr = ptr_next;
        endcase
    end

    assign idx_cmp   = sle_pkg::CMP_W'(idx_reg);
    assign cnt_cmp   = sle_pkg::CMP_W'(count_reg);
    assign ptr_plus2 = {1'b0, ptr_reg} + (sle_pkg::CNT_W + 1)'(2);

    always_comb
    begin
        flags.mode     = mode_reg;
        flags.full     = (count_reg == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
        flags.empty    = (count_reg == '0);
        flags.idx_oob  = (idx_cmp >= cnt_cmp);
        flags.idx_last = ((idx_cmp + 1'b1) == cnt_cmp);
        flags.ge       = ($signed(rdata) >= value_reg);
        flags.ptr_one  = (ptr_reg == sle_pkg::CNT_W'(1));
        flags.rem_last = (ptr_plus2 == {1'b0, count_reg});
    end

    always_comb
    begin
        unique case (mode_reg)
            sle_pkg::MODE_INSERT: err_status = sle_pkg::ST_FULL;
            sle_pkg::MODE_REMOVE: err_status = (count_reg == '0) ? sle_pkg::ST_EMPTY
                                                                  : sle_pkg::ST_RANGE;
            default:              err_status = sle_pkg::ST_RANGE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish && cmd.fin == sle_pkg::FIN_INSERT)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.finish && cmd.fin == sle_pkg::FIN_REMOVE)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            mode_reg  <= req.mode;
            value_reg <= req.value;
            idx_reg   <= req.index;
        end
        if (cmd.finish)
        begin
            rsp_reg.read_value  <= (cmd.fin == sle_pkg::FIN_READ) ? $signed(rdata) : '0;
            rsp_reg.status      <= (cmd.fin == sle_pkg::FIN_ERROR) ? err_status
                                                                    : sle_pkg::ST_OK;
            rsp_reg.entry_count <= sle_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
        else $error("entry count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && cmd.fin == sle_pkg::FIN_INSERT) |=>
            (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance the count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (ptr_reg < sle_pkg::CNT_W'(sle_pkg::CAPACITY)))
        else $error("write beyond the entry store");

endmodule

@@ rtl/sorted_list_engine_top.sv @@
// Top level of the sorted list engine: controller plus datapath.
//
// Keeps up to 64 signed 32-bit entries in ascending order. A command word
// (req: mode, value, index) is taken at the rising edge where start is high
// and busy is low. Mode selects insert (value goes ahead of equal entries),
// remove at index, or read at index. Each command produces exactly one
// result word on rsp (read_value, status, entry_count), shown for one cycle
// with done high; the receiver must take it then, it cannot stall.
//
// Work per command: an insert moves each entry not less than the new value
// up one slot, and a remove moves each entry above the removed index down
// one slot. The work is set by the one write and one read port of the
// entry RAM: one slot moves per cycle. busy falls with done, so the next
// word is taken at the edge that ends the done cycle.
//
// Reset clears the entry count and the controller; RAM contents are not
// cleared, and values read from outside the held entries never reach a result.
module sorted_list_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sle_pkg::req_t req,
    output logic          done,
    output sle_pkg::rsp_t rsp
);

    sle_pkg::cmd_t   cmd;
    sle_pkg::flags_t flags;

    // Sequence each command: decode, walk the list, finish.
    sle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .flags (flags),
        .cmd   (cmd)
    );

    // Hold the entries, the count and the registered result word.
    sle_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .flags (flags),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

@@ tb/sv/sorted_list_engine_top_tb.sv @@
// Self-checking testbench for the sorted list engine: directed table, then biased random commands.
`timescale 1ns / 1ps

module sorted_list_engine_top_tb;

    import sle_pkg::*;

    // Mode code the engine does not define; it must come back as a range error.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1825;
    // Longest honest quiet stretch is an insert ahead of 63 entries plus the
    // longest sender gap; allow many times that.
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // One row of the directed table. When has_reply is set, reply is the
    // hand-written result; otherwise the shadow list supplies it.
    typedef struct {
        req_t word;
        bit   has_reply;
        rsp_t reply;
    } table_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;

    // Shadow copy of the engine's sorted list.
    logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
    int                       shadow_count;

    rsp_t       pending_replies [$];
    table_row_t directed_rows [$];

    int  error_count;
    int  words_sent;
    int  replies_seen;
    int  full_refusals;
    int  peak_count;
    int  stall_cycles;
    bit  gaps_on;

    sorted_list_engine_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one command to the shadow list and return the result it must give.
    function automatic rsp_t shadow_apply(req_t w);
        rsp_t r;
        int   pos;
        r.read_value  = '0;
        r.status      = ST_OK;
        case (w.mode)
            MODE_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // Land ahead of any equal entries: stop at the first one not less.
                    pos = 0;
                    while (pos < shadow_count && shadow_vals[pos] < w.value)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_vals[i] = shadow_vals[i - 1];
                    shadow_vals[pos] = w.value;
                    shadow_count++;
                end
            end
            MODE_REMOVE:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else if (int'(w.index) >= shadow_count)
                    r.status = ST_RANGE;
                else
                begin
                    // Close the gap from the removed slot upward.
                    for (int i = int'(w.index); i + 1 < shadow_count; i++)
                        shadow_vals[i] = shadow_vals[i + 1];
                    shadow_count--;
                end
            end
            MODE_READ:
            begin
                if (int'(w.index) >= shadow_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = shadow_vals[w.index];
            end
            default:
            begin
                r.status = ST_RANGE;
            end
        endcase
        r.entry_count = shadow_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic table_row_t table_row(logic [1:0] mode, logic signed [DATA_W-1:0] value,
                                             logic [INDEX_W-1:0] index, bit has_reply,
                                             logic signed [DATA_W-1:0] read_value,
                                             status_t status, logic [COUNT_OUT_W-1:0] count);
        table_row_t row;
        row.word.mode          = mode;
        row.word.value         = value;
        row.word.index         = index;
        row.has_reply          = has_reply;
        row.reply.read_value   = read_value;
        row.reply.status       = status;
        row.reply.entry_count  = count;
        return row;
    endfunction

    // Build a random command. Most index picks land on a held entry so that
    // removes and reads do real work; the rest roam the whole index range.
    function automatic req_t random_word(mix_t mix);
        req_t w;
        int   roll;
        int   pick;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  w.mode = (roll < 75) ? MODE_INSERT : (roll < 90) ? MODE_READ : MODE_REMOVE;
            MIX_DRAIN: w.mode = (roll < 70) ? MODE_REMOVE : (roll < 90) ? MODE_READ : MODE_INSERT;
            default:   w.mode = (roll < 34) ? MODE_INSERT : (roll < 67) ? MODE_REMOVE : MODE_READ;
        endcase
        if ($urandom_range(0, 99) < 4)
            w.mode = MODE_UNUSED;

        // Mix wide values with a narrow pool (to force duplicates) and extremes.
        pick = $urandom_range(0, 99);
        if (pick < 50)
            w.value = $urandom;
        else if (pick < 85)
            w.value = int'($urandom_range(0, 15)) - 8;
        else
        begin
            case ($urandom_range(0, 3))
                0:       w.value = 32'sh8000_0000;
                1:       w.value = 32'sh7FFF_FFFF;
                2:       w.value = -32'sd1;
                default: w.value = '0;
            endcase
        end

        if (shadow_count > 0 && $urandom_range(0, 9) != 0)
            w.index = INDEX_W'($urandom_range(0, shadow_count - 1));
        else
            w.index = INDEX_W'($urandom_range(0, 63));
        return w;
    endfunction

    // Present one command word and hold it until the engine takes it.
    // Enter and leave just after a falling edge.
    task automatic send_word(req_t w, bit has_reply, rsp_t reply);
        rsp_t predicted;
        // Idle now and then; once in a while the gap is long enough to run
        // past the end of the current operation.
        while (gaps_on && $urandom_range(0, 99) < 12)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 80)) @(negedge clk);
            else
                @(negedge clk);
        end
        start <= 1'b1;
        req   <= w;
        // busy only moves on a rising edge, so its value here is what the
        // next rising edge sees.
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predicted = shadow_apply(w);
        pending_replies.push_back(has_reply ? reply : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // Check every result word against the oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && done)
        begin
            replies_seen++;
            if (rsp.status == ST_FULL)
                full_refusals++;
            if (int'(rsp.entry_count) > peak_count)
                peak_count = int'(rsp.entry_count);
            if (pending_replies.size() == 0)
            begin
                $error("result word with no command outstanding: %p", rsp);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: abort when neither side moves a word for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
            $display("sorted_list_engine_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        mix_t mix;
        int   left_in_mix;

        rst_n         = 1'b0;
        start         = 1'b0;
        req           = '0;
        error_count   = 0;
        words_sent    = 0;
        replies_seen  = 0;
        full_refusals = 0;
        peak_count    = 0;
        stall_cycles  = 0;
        gaps_on       = 1'b1;
        shadow_count  = 0;
        mix           = MIX_FILL;
        left_in_mix   = 0;
        foreach (shadow_vals[i])
            shadow_vals[i] = '0;

        // Empty list: every remove and read fails, and so does the unused mode.
        directed_rows.push_back(table_row(MODE_REMOVE, '0, 6'd0, 1, '0, ST_EMPTY, 7'd0));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd0, 1, '0, ST_RANGE, 7'd0));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd63, 1, '0, ST_RANGE, 7'd0));
        directed_rows.push_back(table_row(MODE_REMOVE, '0, 6'd63, 1, '0, ST_EMPTY, 7'd0));
        directed_rows.push_back(table_row(MODE_UNUSED, '0, 6'd0, 1, '0, ST_RANGE, 7'd0));
        // Extremes of the value range, inserted largest first.
        directed_rows.push_back(table_row(MODE_INSERT, 32'sh7FFF_FFFF, 6'd0, 1,
                                          '0, ST_OK, 7'd1));
        directed_rows.push_back(table_row(MODE_INSERT, 32'sh8000_0000, 6'd0, 1,
                                          '0, ST_OK, 7'd2));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd0, 1,
                                          32'sh8000_0000, ST_OK, 7'd2));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd1, 1,
                                          32'sh7FFF_FFFF, ST_OK, 7'd2));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd2, 1, '0, ST_RANGE, 7'd2));
        // Duplicates and a value just below zero.
        directed_rows.push_back(table_row(MODE_INSERT, 32'sd0, 6'd0, 0, '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_INSERT, 32'sd0, 6'd0, 0, '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_INSERT, -32'sd1, 6'd0, 0, '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_INSERT, 32'sh7FFF_FFFF, 6'd0, 0,
                                          '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd1, 0, '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd4, 0, '0, ST_OK, 7'd0));
        // Remove past the end leaves six entries in place.
        directed_rows.push_back(table_row(MODE_REMOVE, '0, 6'd6, 1, '0, ST_RANGE, 7'd6));
        directed_rows.push_back(table_row(MODE_REMOVE, '0, 6'd63, 1, '0, ST_RANGE, 7'd6));
        // Remove the top entry, then the bottom one.
        directed_rows.push_back(table_row(MODE_REMOVE, '0, 6'd5, 0, '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_REMOVE, '0, 6'd0, 0, '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_UNUSED, 32'shFFFF_FFFF, 6'h3F, 1,
                                          '0, ST_RANGE, 7'd4));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd0, 0, '0, ST_OK, 7'd0));
        // Alternating bit patterns in value and index.
        directed_rows.push_back(table_row(MODE_INSERT, 32'sh5555_5555, 6'h2A, 0,
                                          '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_INSERT, 32'shAAAA_AAAA, 6'h15, 0,
                                          '0, ST_OK, 7'd0));
        directed_rows.push_back(table_row(MODE_READ, '0, 6'd63, 1, '0, ST_RANGE, 7'd6));

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].has_reply,
                      directed_rows[i].reply);

        // Random part: alternate fill, drain and even mixes so the list
        // swings between empty and full many times.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (left_in_mix == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_DRAIN;
                    default: mix = MIX_EVEN;
                endcase
                left_in_mix = $urandom_range(60, 160);
            end
            left_in_mix--;
            // Run a long stretch back to back with no idle cycles.
            gaps_on = !(n >= 700 && n < 1000);
            send_word(random_word(mix), 1'b0, '0);
        end
        start <= 1'b0;

        // Drain outstanding results, then watch a while for stray strobes.
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d commands, checked %0d results", words_sent, replies_seen);
        $display("list peaked at %0d entries; %0d inserts refused on a full list",
                 peak_count, full_refusals);
        if (error_count == 0)
            $display("sorted_list_engine_top_tb: done, clean");
        else
            $display("sorted_list_engine_top_tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_ctrl.sv
rtl/sle_dp.sv
rtl/sorted_list_engine_top.sv
tb/sv/sorted_list_engine_top_tb.sv
